// ===== rtl/core/rsma_pkg.sv =====
// shared types, constants and op codes of the slot map allocator
// no dependencies
package rsma_pkg;
  localparam int unsigned Tokens    = 8;
  localparam int unsigned Branches  = 16;
  localparam int unsigned Slots     = 64;
  localparam int unsigned TokW      = $clog2(Tokens);
  localparam int unsigned BrW       = $clog2(Branches);
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned EntW      = TokW + BrW;
  localparam int unsigned TopW      = SlotW + 1;
  localparam int unsigned CntW      = 4;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [3:0] FN_CLAIM    = 4'd0;
  localparam logic [3:0] FN_CLEAR    = 4'd1;
  localparam logic [3:0] FN_COPY     = 4'd2;
  localparam logic [3:0] FN_RELEASE  = 4'd3;
  localparam logic [3:0] FN_ALLOC    = 4'd4;
  localparam logic [3:0] FN_VALIDATE = 4'd5;
  localparam logic [3:0] FN_INVAL    = 4'd6;
  localparam logic [3:0] FN_INVALALL = 4'd7;
  localparam logic [3:0] FN_QUERY    = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_TOKEN = 2'd1;
  localparam logic [1:0] ST_NO_SLOT  = 2'd2;
  localparam logic [1:0] ST_NO_ALLOC = 2'd3;

  // map entry: used flag and slot
  typedef struct packed {
    logic             used;
    logic [SlotW-1:0] slot;
  } map_ent_t;

  // slot record: use count and up-to-date mark
  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic            fresh;
  } slot_rec_t;
endpackage

// ===== rtl/core/rsma_map_mem.sv =====
// branch map store, one entry per token and branch, with per-entry valid bits
// depends on rsma_pkg
module rsma_map_mem (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [rsma_pkg::EntW-1:0] raddr_i,
  output rsma_pkg::map_ent_t    rdata_o,
  input  logic                  we_i,
  input  logic [rsma_pkg::EntW-1:0] waddr_i,
  input  rsma_pkg::map_ent_t    wdata_i
);
  import rsma_pkg::*;
  localparam int unsigned Depth = Tokens * Branches;

  logic [SlotW-1:0] mem [Depth];
  logic [Depth-1:0] used_q;
  logic [SlotW-1:0] rslot_q;
  logic             rused_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i.slot;
    rslot_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      rused_q <= 1'b0;
    end else begin
      if (we_i) used_q[waddr_i] <= wdata_i.used;
      rused_q <= used_q[raddr_i];
    end
  end

  assign rdata_o.used = rused_q;
  assign rdata_o.slot = rused_q ? rslot_q : '0;
endmodule

// ===== rtl/core/rsma_slot_mem.sv =====
// slot records and free stack; records carry valid bits so reset reads zero
// depends on rsma_pkg
module rsma_slot_mem (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [rsma_pkg::SlotW-1:0] raddr_i,
  output rsma_pkg::slot_rec_t    rdata_o,
  input  logic                   we_i,
  input  logic [rsma_pkg::SlotW-1:0] waddr_i,
  input  rsma_pkg::slot_rec_t    wdata_i,
  input  logic [rsma_pkg::SlotW-1:0] fs_raddr_i,
  output logic [rsma_pkg::SlotW-1:0] fs_rdata_o,
  input  logic                   fs_we_i,
  input  logic [rsma_pkg::SlotW-1:0] fs_waddr_i,
  input  logic [rsma_pkg::SlotW-1:0] fs_wdata_i
);
  import rsma_pkg::*;

  slot_rec_t        rec_mem [Slots];
  logic [Slots-1:0] rec_vld_q;
  slot_rec_t        rrec_q;
  logic             rvld_q;
  logic [SlotW-1:0] fs_mem [Slots];
  logic [Slots-1:0] fs_vld_q;
  logic [SlotW-1:0] fs_q;
  logic             fs_vld_rd_q;
  logic [SlotW-1:0] fs_addr_q;

  always_ff @(posedge clk_i) begin
    if (we_i) rec_mem[waddr_i] <= wdata_i;
    rrec_q <= rec_mem[raddr_i];
    if (fs_we_i) fs_mem[fs_waddr_i] <= fs_wdata_i;
    fs_q      <= fs_mem[fs_raddr_i];
    fs_addr_q <= fs_raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q   <= '0;
      rvld_q      <= 1'b0;
      fs_vld_q    <= '0;
      fs_vld_rd_q <= 1'b0;
    end else begin
      if (we_i) rec_vld_q[waddr_i] <= 1'b1;
      rvld_q <= rec_vld_q[raddr_i];
      if (fs_we_i) fs_vld_q[fs_waddr_i] <= 1'b1;
      fs_vld_rd_q <= fs_vld_q[fs_raddr_i];
    end
  end

  assign rdata_o    = rvld_q ? rrec_q : '0;
  // unwritten stack entry i holds slot i
  assign fs_rdata_o = fs_vld_rd_q ? fs_q : fs_addr_q;
endmodule

// ===== rtl/core/refcounted_slot_map_allocator_unit.sv =====
// Slot map allocator: one item in, one result item out. Each item is run by a
// sequencer over the map memory and the slot memory, both with registered reads.
// Single-entry ops (allocate, validate, invalidate, query, unknown) act on one
// map entry; clear, copy, release and invalidate all walk the token's 16 map
// entries one by one, bounded by the single read port of each memory. No item
// is taken while one is in work or its result waits. Depends on rsma_pkg,
// rsma_map_mem and rsma_slot_mem.
module refcounted_slot_map_allocator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // func[3:0], token[6:4], src_token[9:7], branch[13:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // token_index[2:0], slot[8:3], allocated[9],
                                      // slot_fresh[10], status[12:11]
);
  import rsma_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RDMAP = 4'd1; // map read issued
  localparam logic [3:0] S_MAP   = 4'd2; // map data back, act
  localparam logic [3:0] S_SLOT  = 4'd3; // slot record back, modify
  localparam logic [3:0] S_FS    = 4'd4; // free stack data back (allocate)
  localparam logic [3:0] S_NEXT  = 4'd5; // next branch of a walk
  localparam logic [3:0] S_FIN   = 4'd6; // read final entry
  localparam logic [3:0] S_FIN2  = 4'd7;
  localparam logic [3:0] S_FIN3  = 4'd8; // slot record of final entry back
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]       state_q, state_d;
  logic [3:0]       func_q;
  logic [TokW-1:0]  tok_q, src_q, rtok_q;
  logic [BrW-1:0]   br_q, wb_q;
  logic [1:0]       status_q;
  logic [TopW-1:0]  top_q;
  logic [Tokens-1:0] act_q;
  map_ent_t         ent_q, old_q;
  logic [SlotW-1:0] oslot_q;
  logic             oalloc_q, ofresh_q;

  logic [EntW-1:0]  m_raddr, m_waddr;
  map_ent_t         m_rdata, m_wdata;
  logic             m_we;
  logic [SlotW-1:0] s_raddr, s_waddr, fs_raddr, fs_waddr, fs_wdata, fs_rdata;
  slot_rec_t        s_rdata, s_wdata;
  logic             s_we, fs_we;

  rsma_map_mem u_map (
    .clk_i, .rst_ni, .raddr_i(m_raddr), .rdata_o(m_rdata),
    .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata)
  );
  rsma_slot_mem u_slot (
    .clk_i, .rst_ni, .raddr_i(s_raddr), .rdata_o(s_rdata),
    .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .fs_raddr_i(fs_raddr), .fs_rdata_o(fs_rdata),
    .fs_we_i(fs_we), .fs_waddr_i(fs_waddr), .fs_wdata_i(fs_wdata)
  );

  logic walk;
  assign walk = (func_q == FN_CLEAR) || (func_q == FN_COPY) ||
                (func_q == FN_RELEASE) || (func_q == FN_INVALALL);

  // lowest inactive token
  logic             tok_free;
  logic [TokW-1:0]  tok_first;
  always_comb begin
    tok_free  = 1'b0;
    tok_first = '0;
    for (int i = Tokens - 1; i >= 0; i--) begin
      if (!act_q[i]) begin
        tok_free  = 1'b1;
        tok_first = TokW'(i);
      end
    end
  end

  logic [BrW-1:0]  cur_br;
  logic [TokW-1:0] rd_tok;
  assign cur_br = walk ? wb_q : br_q;
  // copy reads the source map, everything else its own token
  assign rd_tok = (func_q == FN_COPY) ? src_q : tok_q;

  always_comb begin
    state_d  = state_q;
    m_raddr  = {rd_tok, cur_br};
    m_we     = 1'b0;
    m_waddr  = {tok_q, cur_br};
    m_wdata  = '0;
    s_raddr  = m_rdata.slot;
    s_we     = 1'b0;
    s_waddr  = ent_q.slot;
    s_wdata  = s_rdata;
    fs_raddr = top_q[SlotW-1:0] - SlotW'(1);
    fs_we    = 1'b0;
    fs_waddr = top_q[SlotW-1:0];
    fs_wdata = ent_q.slot;
    case (state_q)
      S_IDLE:  if (s_axis_tvalid) state_d = S_RDMAP;
      S_RDMAP: begin
        if (func_q == FN_CLAIM) state_d = S_FIN;
        else if (func_q == FN_CLEAR) begin
          m_we    = 1'b1;
          state_d = S_NEXT;
        end else state_d = S_MAP;
      end
      S_MAP: begin
        // m_rdata valid; slot read issued at its slot
        case (func_q)
          FN_ALLOC: state_d = m_rdata.used ? S_FIN : S_FS;
          FN_VALIDATE, FN_INVAL, FN_COPY, FN_RELEASE, FN_INVALALL:
            state_d = m_rdata.used ? S_SLOT : (walk ? S_NEXT : S_FIN);
          default: state_d = S_FIN;
        endcase
        if ((func_q == FN_COPY) || ((func_q != FN_VALIDATE) && m_rdata.used
            && (func_q != FN_QUERY) && (func_q != FN_ALLOC) && (func_q <= FN_QUERY))
            || ((func_q == FN_RELEASE || func_q == FN_INVALALL) && !m_rdata.used)) begin
          m_we    = 1'b1;
          m_wdata = (func_q == FN_COPY) ? m_rdata : '0;
        end
        if (func_q == FN_COPY && !m_rdata.used) state_d = S_NEXT;
      end
      S_SLOT: begin
        s_we = 1'b1;
        if (func_q == FN_VALIDATE) s_wdata.fresh = 1'b1;
        else if (func_q == FN_COPY) begin
          if (s_rdata.cnt != CntMax) s_wdata.cnt = s_rdata.cnt + CntW'(1);
        end else begin
          if (s_rdata.cnt != '0) begin
            s_wdata.cnt = s_rdata.cnt - CntW'(1);
            if ((s_rdata.cnt == CntW'(1)) && (top_q != TopW'(Slots))) fs_we = 1'b1;
          end
        end
        state_d = walk ? S_NEXT : S_FIN;
      end
      S_FS: begin
        if (top_q == '0) state_d = S_FIN;
        else begin
          m_we           = 1'b1;
          m_wdata.used   = 1'b1;
          m_wdata.slot   = fs_rdata;
          s_we           = 1'b1;
          s_waddr        = fs_rdata;
          s_wdata.cnt    = CntW'(1);
          s_wdata.fresh  = 1'b0;
          state_d        = S_FIN;
        end
      end
      S_NEXT: begin
        if (wb_q == BrW'(Branches - 1)) state_d = S_FIN;
        else state_d = S_RDMAP;
      end
      S_FIN: begin
        m_raddr = {tok_q, br_q};
        state_d = S_FIN2;
      end
      S_FIN2:  state_d = S_FIN3;
      S_FIN3:  state_d = S_OUT;
      S_OUT:   if (m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      top_q    <= TopW'(Slots);
      act_q    <= '0;
      wb_q     <= '0;
      status_q <= ST_OK;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          wb_q     <= '0;
          status_q <= ST_OK;
        end
        S_RDMAP: begin
          if (func_q == FN_CLAIM) begin
            if (tok_free) act_q[tok_first] <= 1'b1;
            else status_q <= ST_NO_TOKEN;
          end
        end
        S_MAP: begin
          if ((func_q == FN_VALIDATE || func_q == FN_QUERY) && !m_rdata.used)
            status_q <= ST_NO_ALLOC;
        end
        S_SLOT: if (fs_we) top_q <= top_q + TopW'(1);
        S_FS: begin
          if (top_q == '0) status_q <= ST_NO_SLOT;
          else top_q <= top_q - TopW'(1);
        end
        S_NEXT: begin
          wb_q <= wb_q + BrW'(1);
          if (wb_q == BrW'(Branches - 1) && func_q == FN_RELEASE) act_q[tok_q] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && s_axis_tvalid) begin
      func_q <= s_axis_tdata[3:0];
      tok_q  <= s_axis_tdata[6:4];
      rtok_q <= s_axis_tdata[6:4];
      src_q  <= s_axis_tdata[9:7];
      br_q   <= s_axis_tdata[13:10];
    end
    if (state_q == S_RDMAP && func_q == FN_CLAIM && tok_free) begin
      tok_q  <= tok_first;
      rtok_q <= tok_first;
    end
    if (state_q == S_MAP) ent_q <= m_rdata;
    if (state_q == S_FIN2) old_q <= m_rdata;
    if (state_q == S_FIN3) begin
      oslot_q  <= old_q.slot;
      oalloc_q <= old_q.used;
      ofresh_q <= old_q.used & s_rdata.fresh;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {3'b000, status_q, ofresh_q, oalloc_q, oslot_q, rtok_q};
endmodule

// ===== rtl/core/rsma_checker.sv =====
// port-level checks of the allocator's stream handshake and result fields
// binds to refcounted_slot_map_allocator_unit
module rsma_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import rsma_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
    else $error("item accepted while busy");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input open while result pending");
  a_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[9] |-> m_axis_tdata[10] == 1'b0 && m_axis_tdata[8:3] == '0)
    else $error("unmapped entry reported with slot data");
endmodule

bind refcounted_slot_map_allocator_unit rsma_checker u_rsma_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// ===== sim/refcounted_slot_map_allocator_unit_test.sv =====
// testbench for the slot map allocator: directed table then random ops,
// every result checked against a behavioral predictor of the slot pool
// depends on rsma_pkg and refcounted_slot_map_allocator_unit
`timescale 1ns / 100ps

module refcounted_slot_map_allocator_unit_test;
  import rsma_pkg::*;

  // first member is the top bits, so tok lands in [2:0] as on the port
  typedef struct packed {
    logic [1:0] status;
    logic       fresh;
    logic       alloc;
    logic [5:0] slot;
    logic [2:0] tok;
  } pool_res_t;

  typedef struct {
    logic [3:0] func;
    logic [2:0] tok;
    logic [2:0] src;
    logic [3:0] br;
    bit         fixed;   // expected result typed in below
    pool_res_t  res;
  } op_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  refcounted_slot_map_allocator_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("refcounted_slot_map_allocator_unit_test: FAIL");
    $finish;
  end

  // predictor state
  bit         ent_used [128];
  logic [5:0] ent_slot [128];
  int         ref_cnt  [64];
  bit         fresh_mk [64];
  logic [5:0] free_stk [64];
  int         free_top;
  bit         tok_busy [8];

  pool_res_t  pending_res [$];
  int         errors = 0, n_items = 0, n_results = 0;
  int         n_nofree_slot = 0, n_nofree_tok = 0;
  bit         idle_ok = 1'b1;   // random idling enabled

  function automatic void drop_slot(logic [5:0] s);
    if (ref_cnt[s] == 0) return;
    ref_cnt[s]--;
    if (ref_cnt[s] == 0 && free_top < 64) begin
      free_stk[free_top] = s;
      free_top++;
    end
  endfunction

  function automatic void unmap(int e);
    if (ent_used[e]) drop_slot(ent_slot[e]);
    ent_used[e] = 1'b0;
    ent_slot[e] = '0;
  endfunction

  function automatic pool_res_t pool_predict(logic [3:0] func, logic [2:0] tk,
                                             logic [2:0] sr, logic [3:0] br);
    pool_res_t r;
    int        t, e;
    logic [1:0] st;
    st = ST_OK;
    t = tk;
    case (func)
      FN_CLAIM: begin
        st = ST_NO_TOKEN;
        for (int i = 0; i < 8; i++)
          if (!tok_busy[i]) begin
            tok_busy[i] = 1'b1;
            t = i;
            st = ST_OK;
            break;
          end
      end
      FN_CLEAR: for (int b = 0; b < 16; b++) begin
        ent_used[t*16+b] = 1'b0;
        ent_slot[t*16+b] = '0;
      end
      FN_COPY: for (int b = 0; b < 16; b++) begin
        bit u;
        logic [5:0] s;
        u = ent_used[sr*16+b];
        s = ent_slot[sr*16+b];
        ent_used[t*16+b] = u;
        ent_slot[t*16+b] = u ? s : '0;
        if (u && ref_cnt[s] < 15) ref_cnt[s]++;
      end
      FN_RELEASE: begin
        for (int b = 0; b < 16; b++) unmap(t*16+b);
        tok_busy[t] = 1'b0;
      end
      FN_ALLOC: begin
        e = t*16 + br;
        if (!ent_used[e]) begin
          if (free_top == 0) st = ST_NO_SLOT;
          else begin
            free_top--;
            ref_cnt[free_stk[free_top]] = 1;
            fresh_mk[free_stk[free_top]] = 1'b0;
            ent_used[e] = 1'b1;
            ent_slot[e] = free_stk[free_top];
          end
        end
      end
      FN_VALIDATE: begin
        e = t*16 + br;
        if (ent_used[e]) fresh_mk[ent_slot[e]] = 1'b1;
        else st = ST_NO_ALLOC;
      end
      FN_INVAL: unmap(t*16 + br);
      FN_INVALALL: for (int b = 0; b < 16; b++) unmap(t*16+b);
      FN_QUERY: if (!ent_used[t*16+br]) st = ST_NO_ALLOC;
      default: ;
    endcase
    e = t*16 + br;
    r.tok    = t[2:0];
    r.alloc  = ent_used[e];
    r.slot   = ent_used[e] ? ent_slot[e] : '0;
    r.fresh  = ent_used[e] ? fresh_mk[ent_slot[e]] : 1'b0;
    r.status = st;
    if (st == ST_NO_SLOT) n_nofree_slot++;
    if (st == ST_NO_TOKEN) n_nofree_tok++;
    return r;
  endfunction

  // tvalid stays high after an accepted item unless the next one idles first
  task automatic send_op(logic [3:0] func, logic [2:0] tk, logic [2:0] sr,
                         logic [3:0] br, bit fixed, pool_res_t want);
    pool_res_t r;
    while (idle_ok && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, br, sr, tk, func};
    do @(posedge clk_i); while (!s_axis_tready);
    r = pool_predict(func, tk, sr, br);
    if (fixed && r !== want) begin
      errors++;
      $display("table row disagrees with predictor: func %0d row %h pred %h",
               func, want, r);
    end
    pending_res = {pending_res, r};
    n_items++;
  endtask

  // result side
  always @(posedge clk_i) begin
    pool_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[12:0];
      n_results++;
      if (pending_res.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %h", got);
      end else begin
        want = pending_res.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: tok %0d/%0d slot %0d/%0d alloc %0d/%0d fresh %0d/%0d st %0d/%0d",
                     want.tok, got.tok, want.slot, got.slot, want.alloc, got.alloc,
                     want.fresh, got.fresh, want.status, got.status);
        end
      end
    end
    m_axis_tready <= !idle_ok || ($urandom_range(99) >= 13);
  end

  function automatic pool_res_t res_of(logic [2:0] tk, logic [5:0] s, logic a,
                                       logic f, logic [1:0] st);
    pool_res_t r;
    r.tok = tk; r.slot = s; r.alloc = a; r.fresh = f; r.status = st;
    return r;
  endfunction

  op_row_t dir_tbl [$];

  function automatic void add_row(logic [3:0] f, logic [2:0] tk, logic [2:0] sr,
                                  logic [3:0] br, bit fixed, pool_res_t r);
    op_row_t row;
    row.func = f; row.tok = tk; row.src = sr; row.br = br;
    row.fixed = fixed; row.res = r;
    dir_tbl = {dir_tbl, row};
  endfunction

  initial begin
    int         wait_cyc;
    logic [3:0] f;
    for (int i = 0; i < 128; i++) begin ent_used[i] = 0; ent_slot[i] = '0; end
    for (int i = 0; i < 64; i++) begin
      ref_cnt[i] = 0; fresh_mk[i] = 0; free_stk[i] = i[5:0];
    end
    free_top = 64;
    for (int i = 0; i < 8; i++) tok_busy[i] = 0;

    // after reset: queries miss, first allocation pops slot 63
    add_row(FN_QUERY,    3'd7, 3'd0, 4'd15, 1, res_of(3'd7, 6'd0, 0, 0, ST_NO_ALLOC));
    add_row(FN_VALIDATE, 3'd0, 3'd0, 4'd0,  1, res_of(3'd0, 6'd0, 0, 0, ST_NO_ALLOC));
    add_row(FN_CLAIM,    3'd5, 3'd0, 4'd0,  1, res_of(3'd0, 6'd0, 0, 0, ST_OK));
    add_row(FN_ALLOC,    3'd0, 3'd0, 4'd0,  1, res_of(3'd0, 6'd63, 1, 0, ST_OK));
    add_row(FN_VALIDATE, 3'd0, 3'd0, 4'd0,  1, res_of(3'd0, 6'd63, 1, 1, ST_OK));
    add_row(FN_ALLOC,    3'd7, 3'd7, 4'd15, 1, res_of(3'd7, 6'd62, 1, 0, ST_OK));
    add_row(FN_COPY,     3'd3, 3'd7, 4'd15, 0, '0);
    add_row(FN_INVAL,    3'd7, 3'd0, 4'd15, 0, '0);
    add_row(FN_QUERY,    3'd3, 3'd0, 4'd15, 0, '0);
    add_row(FN_RELEASE,  3'd3, 3'd0, 4'd15, 0, '0);
    add_row(4'd9,        3'd0, 3'd0, 4'd0,  0, '0);
    add_row(4'd15,       3'd7, 3'd7, 4'd15, 0, '0);
    for (int i = 0; i < 8; i++) add_row(FN_CLAIM, 3'd0, 3'd0, 4'd0, 0, '0);
    add_row(FN_INVALALL, 3'd0, 3'd0, 4'd0, 0, '0);
    add_row(FN_CLEAR,    3'd7, 3'd0, 4'd0, 0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i])
      send_op(dir_tbl[i].func, dir_tbl[i].tok, dir_tbl[i].src, dir_tbl[i].br,
              dir_tbl[i].fixed, dir_tbl[i].res);

    for (int n = 0; n < 1530; n++) begin
      idle_ok = !(n >= 600 && n < 800);
      // mostly allocate/validate/query so the pool fills up; bulk ops rarer
      case ($urandom_range(99)) inside
        [0:39]:  f = FN_ALLOC;
        [40:51]: f = FN_VALIDATE;
        [52:63]: f = FN_QUERY;
        [64:71]: f = FN_INVAL;
        [72:77]: f = FN_COPY;
        [78:83]: f = FN_CLAIM;
        [84:88]: f = FN_RELEASE;
        [89:92]: f = FN_INVALALL;
        [93:96]: f = FN_CLEAR;
        default: f = 4'($urandom_range(15, 9));
      endcase
      send_op(f, 3'($urandom), 3'($urandom), 4'($urandom), 0, '0);
    end
    s_axis_tvalid <= 1'b0;
    idle_ok = 1'b1;

    wait_cyc = 0;
    while (pending_res.size() != 0 && wait_cyc < 100000) begin
      @(posedge clk_i);
      wait_cyc++;
    end
    repeat (100) @(posedge clk_i);
    $display("ran %0d items, %0d results; pool-empty hits %0d, token-full hits %0d",
             n_items, n_results, n_nofree_slot, n_nofree_tok);
    if (errors == 0 && pending_res.size() == 0)
      $display("refcounted_slot_map_allocator_unit_test: PASS");
    else
      $display("refcounted_slot_map_allocator_unit_test: FAIL");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/rsma_pkg.sv
rtl/core/rsma_map_mem.sv
rtl/core/rsma_slot_mem.sv
rtl/core/refcounted_slot_map_allocator_unit.sv
rtl/core/rsma_checker.sv
sim/refcounted_slot_map_allocator_unit_test.sv
